// ===== hw/rtl/lph_pkg.sv =====
// ----------------------------------------------------------------------------
// lph_pkg: shared types and constants for the linear probe hash table
// Table geometry, operation and status codes, slot entry layout, transfers.
// ----------------------------------------------------------------------------
package lph_pkg;

  // TABLE_SLOTS must be a power of two (home slot and wrap use the low bits)
  localparam int TABLE_SLOTS     = 1024;
  localparam int VALUE_BITS      = 32;
  localparam int SLOT_BITS       = $clog2(TABLE_SLOTS);
  localparam int LIVE_BITS       = SLOT_BITS + 1;
  localparam int HALF_SLOTS      = TABLE_SLOTS / 2;
  localparam int SLOT_INDEX_BITS = 10;

  localparam logic [31:0] HASH_MULT  = 32'd2654435761;
  localparam int          HASH_SHIFT = 8;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic REG_KEY_KIND = 1'b0;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_t;

  typedef struct packed {
    mark_t                  mark;
    logic [31:0]            key;
    logic [VALUE_BITS-1:0]  value;
  } slot_entry_t;

  localparam int ENTRY_BITS = $bits(slot_entry_t);

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic [31:0]                found_value;
    logic [SLOT_INDEX_BITS-1:0] slot_index;
  } out_item_t;

  typedef struct packed {
    logic                  we;
    logic [SLOT_BITS-1:0]  waddr;
    slot_entry_t           wdata;
    logic [SLOT_BITS-1:0]  raddr;
  } ram_req_t;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_HASH  = 4'b0100,
    S_PROBE = 4'b1000
  } state_t;

endpackage

// ===== hw/rtl/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table: open addressing key/value table, linear probing
//
// A command (mode, key, value on item) transfers on a rising edge with start
// high and busy low. Insert, remove and lookup each give one result on
// result, marked by done for exactly one cycle; the receiver cannot stall it.
// A new command may transfer during the done cycle. Unused modes and inserts
// into a table that is at least half full answer from the hash state without
// probing. The walk is set by the single read port of the slot RAM: one slot
// per cycle. After reset the block sweeps all TABLE_SLOTS (1024) slots of the
// slot RAM to empty with busy high. The user writes key_kind over the APB port
// at address 0 only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module linear_probe_hash_table import lph_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_item_t    item,
  output logic        done,
  output out_item_t   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                  key_kind;
  logic                  hash_load;
  logic [SLOT_BITS-1:0]  home;
  ram_req_t              ram_req;
  logic [ENTRY_BITS-1:0] rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_KEY_KIND) ? {31'd0, key_kind} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_kind <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_KEY_KIND)) begin
      key_kind <= pwdata[0];
    end
  end

  lph_hash u_hash (
    .clk      (clk),
    .load     (hash_load),
    .key      (item.key),
    .key_kind (key_kind),
    .home     (home)
  );

  lph_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (TABLE_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

  lph_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .home      (home),
    .rdata     (rdata),
    .hash_load (hash_load),
    .ram_req   (ram_req),
    .busy      (busy),
    .done      (done),
    .result    (result)
  );

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a command in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results back to back");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != ST_OK) |-> (result.found_value == 32'd0) &&
      (result.slot_index == '0))
    else $error("nonzero fields on a failed command");

endmodule

// ===== hw/rtl/lph_ram.sv =====
// ----------------------------------------------------------------------------
// lph_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module lph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lph_hash.sv =====
// ----------------------------------------------------------------------------
// lph_hash: home slot of a key
// Registers the multiplicative hash product and the raw key, then selects.
// ----------------------------------------------------------------------------
module lph_hash import lph_pkg::*; (
  input  logic                 clk,
  input  logic                 load,
  input  logic [31:0]          key,
  input  logic                 key_kind,
  output logic [SLOT_BITS-1:0] home
);

  logic [31:0] product;
  logic [31:0] raw_key;

  always_ff @(posedge clk) begin
    if (load) begin
      product <= key * HASH_MULT;
      raw_key <= key;
    end
  end

  assign home = key_kind ? raw_key[SLOT_BITS-1:0] : product[HASH_SHIFT +: SLOT_BITS];

endmodule

// ===== hw/rtl/lph_engine.sv =====
// ----------------------------------------------------------------------------
// lph_engine: probe sequencer
// Clears the slot RAM after reset, then walks slots one per cycle from the
// home slot, writes back inserts and tombstones, and issues the result.
// ----------------------------------------------------------------------------
module lph_engine import lph_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  in_item_t              item,
  input  logic [SLOT_BITS-1:0]  home,
  input  logic [ENTRY_BITS-1:0] rdata,
  output logic                  hash_load,
  output ram_req_t              ram_req,
  output logic                  busy,
  output logic                  done,
  output out_item_t             result
);

  localparam logic [SLOT_BITS-1:0] SLOT_LAST  = SLOT_BITS'(TABLE_SLOTS - 1);
  localparam logic [LIVE_BITS-1:0] LAP_LAST   = LIVE_BITS'(TABLE_SLOTS - 1);
  localparam logic [LIVE_BITS-1:0] FULL_LEVEL = LIVE_BITS'(HALF_SLOTS);

  state_t                state;
  state_t                state_next;
  in_item_t              op;
  logic [SLOT_BITS-1:0]  idx;
  logic [SLOT_BITS-1:0]  idx_next;
  logic [LIVE_BITS-1:0]  probes;
  logic [LIVE_BITS-1:0]  probes_next;
  logic [LIVE_BITS-1:0]  live_count;
  logic [LIVE_BITS-1:0]  live_count_next;
  logic                  fin;
  out_item_t             fin_item;
  slot_entry_t           entry;
  logic                  is_insert;
  logic                  is_search;
  logic                  key_hit;

  assign entry     = slot_entry_t'(rdata);
  assign is_insert = (op.mode == MODE_INSERT);
  assign is_search = (op.mode == MODE_REMOVE) || (op.mode == MODE_LOOKUP);
  assign key_hit   = (entry.mark == MARK_LIVE) && (entry.key == op.key);
  assign busy      = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    probes_next     = probes;
    live_count_next = live_count;
    hash_load       = 1'b0;
    fin             = 1'b0;
    fin_item        = '{status: ST_MISS, found_value: '0, slot_index: '0};
    ram_req         = '{we: 1'b0, waddr: idx, wdata: '0, raddr: idx};
    case (state)
      S_CLEAR: begin
        ram_req.we = 1'b1;
        idx_next   = idx + 1'b1;
        if (idx == SLOT_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          hash_load  = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (!is_insert && !is_search) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end else if (is_insert && (live_count >= FULL_LEVEL)) begin
          fin             = 1'b1;
          fin_item.status = ST_FULL;
          state_next      = S_IDLE;
        end else begin
          ram_req.raddr = home;
          idx_next      = home;
          probes_next   = '0;
          state_next    = S_PROBE;
        end
      end
      S_PROBE: begin
        if (is_insert && (entry.mark != MARK_LIVE)) begin
          ram_req.we          = 1'b1;
          ram_req.wdata       = '{mark: MARK_LIVE, key: op.key,
                                  value: VALUE_BITS'(op.value)};
          live_count_next     = live_count + 1'b1;
          fin                 = 1'b1;
          fin_item.status     = ST_OK;
          fin_item.slot_index = SLOT_INDEX_BITS'(idx);
          state_next          = S_IDLE;
        end else if (is_search && (entry.mark == MARK_EMPTY)) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end else if (is_search && key_hit) begin
          fin                  = 1'b1;
          fin_item.status      = ST_OK;
          fin_item.found_value = 32'(entry.value);
          fin_item.slot_index  = SLOT_INDEX_BITS'(idx);
          state_next           = S_IDLE;
          if (op.mode == MODE_REMOVE) begin
            ram_req.we         = 1'b1;
            ram_req.wdata      = entry;
            ram_req.wdata.mark = MARK_TOMB;
            if (live_count != '0) begin
              live_count_next = live_count - 1'b1;
            end
          end
        end else if (probes == LAP_LAST) begin
          fin             = 1'b1;
          fin_item.status = is_insert ? ST_FULL : ST_MISS;
          state_next      = S_IDLE;
        end else begin
          idx_next      = idx + 1'b1;
          probes_next   = probes + 1'b1;
          ram_req.raddr = idx + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      idx        <= '0;
      probes     <= '0;
      live_count <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      probes     <= probes_next;
      live_count <= live_count_next;
      done       <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (hash_load) begin
      op <= item;
    end
    if (fin) begin
      result <= fin_item;
    end
  end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: linear probe hash table testbench
// Sends insert, remove, lookup and unused commands over the start/busy port
// in random bursts, and writes key_kind over APB between phases. An inline
// model of the slot table predicts each result, and every done transfer is
// checked field by field against the oldest prediction. The phases cover
// both key kinds, tombstone reuse, duplicate keys, a table filled to its
// load limit with rejected inserts, and a heavy removal pass.
// ----------------------------------------------------------------------------
module tb;
  import lph_pkg::*;

  localparam logic [1:0] MODE_UNUSED   = 2'd3;
  localparam logic       KIND_HASHED   = 1'b0;
  localparam logic       KIND_RAW      = 1'b1;
  localparam logic [2:0] KEY_KIND_ADDR = 3'(4 * int'(REG_KEY_KIND));
  localparam int         MAX_PRINTED   = 100;

  class hash_table_scoreboard;
    logic [31:0]           slot_key  [TABLE_SLOTS];
    logic [VALUE_BITS-1:0] slot_val  [TABLE_SLOTS];
    mark_t                 slot_mark [TABLE_SLOTS];
    int unsigned           live_entries;
    logic                  key_kind;
    out_item_t             awaited[$];
    int                    errors;

    function new();
      foreach (slot_mark[i]) slot_mark[i] = MARK_EMPTY;
      live_entries = 0;
      key_kind     = KIND_HASHED;
      errors       = 0;
    endfunction

    function logic [SLOT_BITS-1:0] home_slot(logic [31:0] key);
      logic [31:0] h;
      if (key_kind == KIND_HASHED) begin
        h = key * HASH_MULT;
        h = h >> HASH_SHIFT;
      end else begin
        h = key;
      end
      return h[SLOT_BITS-1:0];
    endfunction

    function bit find_live(logic [31:0] key, output logic [SLOT_BITS-1:0] idx);
      idx = home_slot(key);
      for (int n = 0; n < TABLE_SLOTS; n++) begin
        if (slot_mark[idx] == MARK_EMPTY) return 1'b0;
        if (slot_mark[idx] == MARK_LIVE && slot_key[idx] == key) return 1'b1;
        idx++;
      end
      return 1'b0;
    endfunction

    function void note_command(in_item_t cmd);
      out_item_t            exp;
      logic [SLOT_BITS-1:0] idx;
      int                   n;
      exp.status      = ST_MISS;
      exp.found_value = '0;
      exp.slot_index  = '0;
      case (cmd.mode)
        MODE_INSERT: begin
          if (live_entries * 2 >= TABLE_SLOTS) begin
            exp.status = ST_FULL;
          end else begin
            idx = home_slot(cmd.key);
            for (n = 0; n < TABLE_SLOTS && slot_mark[idx] == MARK_LIVE; n++) idx++;
            if (n < TABLE_SLOTS) begin
              slot_key[idx]  = cmd.key;
              slot_val[idx]  = VALUE_BITS'(cmd.value);
              slot_mark[idx] = MARK_LIVE;
              live_entries++;
              exp.status     = ST_OK;
              exp.slot_index = SLOT_INDEX_BITS'(idx);
            end else begin
              exp.status = ST_FULL;
            end
          end
        end
        MODE_REMOVE, MODE_LOOKUP: begin
          if (find_live(cmd.key, idx)) begin
            exp.status      = ST_OK;
            exp.found_value = 32'(slot_val[idx]);
            exp.slot_index  = SLOT_INDEX_BITS'(idx);
            if (cmd.mode == MODE_REMOVE) begin
              slot_mark[idx] = MARK_TOMB;
              if (live_entries > 0) live_entries--;
            end
          end
        end
        default: ;
      endcase
      awaited.push_back(exp);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("[%0t] error: %s", $time, msg);
    endtask

    task check_result(out_item_t got);
      out_item_t exp;
      if (awaited.size() == 0) begin
        report($sformatf("result with none expected: status %0d value %h slot %0d",
                         got.status, got.found_value, got.slot_index));
        return;
      end
      exp = awaited.pop_front();
      if (got.status !== exp.status)
        report($sformatf("status %0d, expected %0d", got.status, exp.status));
      if (got.found_value !== exp.found_value)
        report($sformatf("found_value %h, expected %h", got.found_value, exp.found_value));
      if (got.slot_index !== exp.slot_index)
        report($sformatf("slot_index %0d, expected %0d", got.slot_index, exp.slot_index));
    endtask
  endclass

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        start   = 1'b0;
  in_item_t    item    = '0;
  logic        busy;
  logic        done;
  out_item_t   result;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  hash_table_scoreboard sb;
  logic [31:0]          key_log[$];
  logic [31:0]          key_bases[4];
  int                   burst_left = 0;

  linear_probe_hash_table u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(result);
  end

  task automatic send_cmd(logic [1:0] mode, logic [31:0] key, logic [31:0] value);
    in_item_t cmd;
    int       gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd.mode  = mode;
    cmd.key   = key;
    cmd.value = value;
    item  <= cmd;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_command(cmd);
    if (mode == MODE_INSERT) key_log.push_back(key);
  endtask

  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5 && key_log.size() > 0) return key_log[$urandom_range(0, key_log.size() - 1)];
    if (sel < 8) return key_bases[$urandom_range(0, 3)] + ($urandom_range(0, 7) << 18);
    if (sel == 8) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic random_cmd(int ins_pct, int rem_pct, int look_pct);
    logic [1:0]  mode;
    logic [31:0] value;
    int          r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) mode = MODE_INSERT;
    else if (r < ins_pct + rem_pct) mode = MODE_REMOVE;
    else if (r < ins_pct + rem_pct + look_pct) mode = MODE_LOOKUP;
    else mode = MODE_UNUSED;
    case ($urandom_range(0, 9))
      0:       value = 32'h0000_0000;
      1:       value = 32'hFFFF_FFFF;
      default: value = $urandom;
    endcase
    send_cmd(mode, pick_key(), value);
  endtask

  // hold off until every expected result is in, then let the block go quiet
  task automatic settle();
    start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_key_kind(logic kind);
    while (busy !== 1'b0) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= KEY_KIND_ADDR;
    pwdata  <= 32'(kind);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata[0] !== kind)
      sb.report($sformatf("key_kind read back %b, written %b", prdata[0], kind));
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.key_kind = kind;
  endtask

  initial begin
    #50_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    sb = new();
    foreach (key_bases[i]) key_bases[i] = $urandom;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_key_kind(KIND_HASHED);

    send_cmd(MODE_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_cmd(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(MODE_INSERT, 32'h0000_0000, 32'h1234_5678);
    send_cmd(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_cmd(MODE_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_cmd(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_cmd(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_cmd(MODE_INSERT, 32'h0004_0000, 32'hA5A5_5A5A);
    send_cmd(MODE_LOOKUP, 32'h0004_0000, 32'h0000_0000);
    send_cmd(MODE_LOOKUP, 32'h0008_0000, 32'h0000_0000);
    send_cmd(MODE_REMOVE, 32'hDEAD_BEEF, 32'h0000_0000);
    send_cmd(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(MODE_INSERT, 32'h8000_0000, 32'h8000_0000);
    send_cmd(MODE_INSERT, 32'h7FFF_FFFF, 32'h0000_0001);
    send_cmd(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_cmd(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_cmd(MODE_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    send_cmd(MODE_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(MODE_REMOVE, 32'h0004_0000, 32'h0000_0000);
    send_cmd(MODE_UNUSED, 32'h0000_0000, 32'h0000_0000);

    repeat (40) random_cmd(40, 25, 30);
    settle();
    write_key_kind(KIND_RAW);
    repeat (40) random_cmd(35, 25, 35);

    // fill to the load limit, then hit it with rejected inserts
    while (sb.live_entries * 2 < TABLE_SLOTS) random_cmd(95, 1, 4);
    repeat (12) random_cmd(70, 0, 30);
    repeat (60) random_cmd(10, 65, 25);
    settle();
    write_key_kind(KIND_HASHED);
    repeat (30) random_cmd(40, 25, 30);
    settle();

    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
